>>> src/odd_pkg.sv
// Shared widths, constants, register codes and status types of the occupancy detector.
package odd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned DELAY_W  = 8;
  localparam int unsigned PROX_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned NUM_CHAN   = 2;

  // Hysteresis shift and the highest setpoint that may still be raised
  localparam logic [SAMPLE_W-1:0] HYST     = SAMPLE_W'(5);
  localparam logic [SAMPLE_W-1:0] ADC_MAX  = SAMPLE_W'(1023);
  localparam logic [SAMPLE_W-1:0] HYST_TOP = ADC_MAX - HYST;

  // Register reset values
  localparam logic [DELAY_W-1:0] ON_DELAY_RST  = DELAY_W'(4);
  localparam logic [DELAY_W-1:0] OFF_DELAY_RST = DELAY_W'(25);
  localparam logic [PROX_W-1:0]  PROX_LIM_RST  = PROX_W'(768);
  localparam logic [DELAY_W-1:0] IR_ON_RST     = DELAY_W'(4);
  localparam logic [DELAY_W-1:0] IR_OFF_RST    = DELAY_W'(25);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_DELAY_0  = 3'd0,
    CFG_ON_DELAY_1  = 3'd1,
    CFG_OFF_DELAY_0 = 3'd2,
    CFG_OFF_DELAY_1 = 3'd3,
    CFG_PROX_LIMIT  = 3'd4,
    CFG_IR_ON_COUNT = 3'd5,
    CFG_IR_OFF_COUNT = 3'd6
  } cfg_idx_e;

  // Delays of one current lane
  typedef struct packed {
    logic [DELAY_W-1:0] on_delay;
    logic [DELAY_W-1:0] off_delay;
  } lane_cfg_t;

  // Status of one current lane
  typedef struct packed {
    logic occupied_q;
    logic occupied_d;
  } lane_stat_t;

  // IR debounce settings
  typedef struct packed {
    logic [PROX_W-1:0]  limit;
    logic [DELAY_W-1:0] on_count;
    logic [DELAY_W-1:0] off_count;
  } ir_cfg_t;

  // IR debounce status
  typedef struct packed {
    logic detected_d;
    logic error_d;
    logic error_q;
    logic count_zero_q;
  } ir_stat_t;

endpackage

>>> src/odd_lane.sv
// One current-sense lane: hysteresis threshold and on/off delay debounce.
module odd_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic [odd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [odd_pkg::SAMPLE_W-1:0]  setpoint_i,
  input  odd_pkg::lane_cfg_t            cfg_i,
  output odd_pkg::lane_stat_t           stat_o
);

  logic                         occupied_q, occupied_d;
  logic [odd_pkg::DELAY_W-1:0]  on_cnt_q, on_cnt_d;
  logic [odd_pkg::DELAY_W-1:0]  off_cnt_q, off_cnt_d;
  logic [odd_pkg::SAMPLE_W-1:0] thr;
  logic                         above;

  // Shift the setpoint away from the current status, within the ADC range
  always_comb begin
    thr = setpoint_i;
    if (occupied_q && (setpoint_i >= odd_pkg::HYST)) begin
      thr = setpoint_i - odd_pkg::HYST;
    end else if (!occupied_q && (setpoint_i <= odd_pkg::HYST_TOP)) begin
      thr = setpoint_i + odd_pkg::HYST;
    end
  end

  assign above = (sample_i > thr);

  // Count toward the on or off delay and flip the status once it is reached
  always_comb begin
    occupied_d = occupied_q;
    on_cnt_d   = on_cnt_q;
    off_cnt_d  = off_cnt_q;
    if (above) begin
      if (!occupied_q) begin
        if (on_cnt_q < cfg_i.on_delay) begin
          on_cnt_d = on_cnt_q + 1'b1;
        end else begin
          occupied_d = 1'b1;
          off_cnt_d  = '0;
        end
      end else begin
        off_cnt_d = '0;
      end
    end else begin
      if (occupied_q) begin
        if (off_cnt_q < cfg_i.off_delay) begin
          off_cnt_d = off_cnt_q + 1'b1;
        end else begin
          occupied_d = 1'b0;
          on_cnt_d   = '0;
        end
      end else begin
        on_cnt_d = '0;
      end
    end
  end

  // Advance the lane state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied_q <= 1'b0;
      on_cnt_q   <= '0;
      off_cnt_q  <= '0;
    end else if (advance_i) begin
      occupied_q <= occupied_d;
      on_cnt_q   <= on_cnt_d;
      off_cnt_q  <= off_cnt_d;
    end
  end

  assign stat_o.occupied_q = occupied_q;
  assign stat_o.occupied_d = occupied_d;

endmodule

>>> src/odd_ir.sv
// IR proximity lane: limit compare with on/off count debounce and bus error flag.
module odd_ir (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [odd_pkg::PROX_W-1:0]  proximity_i,
  input  logic                        ack_i,
  input  odd_pkg::ir_cfg_t            cfg_i,
  output odd_pkg::ir_stat_t           stat_o
);

  logic                        detected_q, detected_d;
  logic                        error_q, error_d;
  logic [odd_pkg::DELAY_W-1:0] cnt_q, cnt_d;
  logic [odd_pkg::DELAY_W-1:0] cnt_inc;
  logic                        near;

  assign near    = (proximity_i >= cfg_i.limit);
  assign cnt_inc = cnt_q + 1'b1;

  // Debounce the proximity compare; a failed read drops detection
  always_comb begin
    detected_d = detected_q;
    error_d    = 1'b0;
    cnt_d      = cnt_q;
    if (!ack_i) begin
      detected_d = 1'b0;
      error_d    = 1'b1;
      cnt_d      = '0;
    end else if (!detected_q) begin
      if (near) begin
        if (cnt_inc > cfg_i.on_count) begin
          detected_d = 1'b1;
          cnt_d      = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        cnt_d = '0;
      end
    end else begin
      if (!near) begin
        if (cnt_inc > cfg_i.off_count) begin
          detected_d = 1'b0;
          cnt_d      = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        cnt_d = '0;
      end
    end
  end

  // Advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detected_q <= 1'b0;
      error_q    <= 1'b0;
      cnt_q      <= '0;
    end else if (advance_i) begin
      detected_q <= detected_d;
      error_q    <= error_d;
      cnt_q      <= cnt_d;
    end
  end

  assign stat_o.detected_d   = detected_d;
  assign stat_o.error_d      = error_d;
  assign stat_o.error_q      = error_q;
  assign stat_o.count_zero_q = (cnt_q == '0);

endmodule

>>> src/occupancy_detector_debounce.sv
// Top level of the occupancy detector: config registers, lanes and merging output register.
// Takes one request per clock and returns one result per request. Two current lanes
// and one IR lane update side by side in the cycle a request is accepted; their new
// status is merged into one output register, so a result appears in the cycle after
// acceptance. Each lane's state feeds back into the next request's threshold, so one
// request per cycle is the most that lane update loop takes. While the output register
// holds an untaken result, a new request is taken only in the cycle that result leaves.
// Configuration writes take effect on the next request and should be made while idle.
module occupancy_detector_debounce (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input requests
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [9:0] current_sample_0, [19:10] current_sample_1, [29:20] setpoint_0,
  // [39:30] setpoint_1, [55:40] ir_proximity, [56] ir_ack, [63:57] zero
  input  logic [odd_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // Results
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] occupied_0, [1] occupied_1, [2] ir_detected, [3] ir_error, [7:4] zero
  output logic [odd_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // Configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [odd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [odd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = odd_pkg::SAMPLE_W;
  localparam int unsigned NC = odd_pkg::NUM_CHAN;

  logic [odd_pkg::DELAY_W-1:0] on_delay_q [NC];
  logic [odd_pkg::DELAY_W-1:0] off_delay_q [NC];
  logic [odd_pkg::PROX_W-1:0]  prox_limit_q;
  logic [odd_pkg::DELAY_W-1:0] ir_on_q, ir_off_q;

  logic                  cfg_we;
  logic                  in_accept;
  logic                  out_valid_q;
  logic [NC+1:0]         out_bits_q;

  logic [SW-1:0]         sample [NC];
  logic [SW-1:0]         setpoint [NC];
  odd_pkg::lane_cfg_t    lane_cfg [NC];
  odd_pkg::lane_stat_t   lane_stat [NC];
  logic [NC-1:0]         occ_d;
  logic [NC-1:0]         occ_q;
  odd_pkg::ir_cfg_t      ir_cfg;
  odd_pkg::ir_stat_t     ir_stat;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_delay_q[0]  <= odd_pkg::ON_DELAY_RST;
      on_delay_q[1]  <= odd_pkg::ON_DELAY_RST;
      off_delay_q[0] <= odd_pkg::OFF_DELAY_RST;
      off_delay_q[1] <= odd_pkg::OFF_DELAY_RST;
      prox_limit_q   <= odd_pkg::PROX_LIM_RST;
      ir_on_q        <= odd_pkg::IR_ON_RST;
      ir_off_q       <= odd_pkg::IR_OFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        odd_pkg::CFG_ON_DELAY_0:   on_delay_q[0]  <= cfg_data_i[odd_pkg::DELAY_W-1:0];
        odd_pkg::CFG_ON_DELAY_1:   on_delay_q[1]  <= cfg_data_i[odd_pkg::DELAY_W-1:0];
        odd_pkg::CFG_OFF_DELAY_0:  off_delay_q[0] <= cfg_data_i[odd_pkg::DELAY_W-1:0];
        odd_pkg::CFG_OFF_DELAY_1:  off_delay_q[1] <= cfg_data_i[odd_pkg::DELAY_W-1:0];
        odd_pkg::CFG_PROX_LIMIT:   prox_limit_q   <= cfg_data_i;
        odd_pkg::CFG_IR_ON_COUNT:  ir_on_q        <= cfg_data_i[odd_pkg::DELAY_W-1:0];
        odd_pkg::CFG_IR_OFF_COUNT: ir_off_q       <= cfg_data_i[odd_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a request whenever the output slot is free or drains this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the request
  assign sample[0]   = s_axis_tdata_i[SW-1:0];
  assign sample[1]   = s_axis_tdata_i[2*SW-1:SW];
  assign setpoint[0] = s_axis_tdata_i[3*SW-1:2*SW];
  assign setpoint[1] = s_axis_tdata_i[4*SW-1:3*SW];

  // Current lanes
  for (genvar c = 0; c < NC; c++) begin : g_lane
    assign lane_cfg[c].on_delay  = on_delay_q[c];
    assign lane_cfg[c].off_delay = off_delay_q[c];

    odd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (in_accept),
      .sample_i   (sample[c]),
      .setpoint_i (setpoint[c]),
      .cfg_i      (lane_cfg[c]),
      .stat_o     (lane_stat[c])
    );

    assign occ_d[c] = lane_stat[c].occupied_d;
    assign occ_q[c] = lane_stat[c].occupied_q;
  end

  // IR lane
  assign ir_cfg.limit     = prox_limit_q;
  assign ir_cfg.on_count  = ir_on_q;
  assign ir_cfg.off_count = ir_off_q;

  odd_ir u_ir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (in_accept),
    .proximity_i (s_axis_tdata_i[4*SW+odd_pkg::PROX_W-1:4*SW]),
    .ack_i       (s_axis_tdata_i[4*SW+odd_pkg::PROX_W]),
    .cfg_i       (ir_cfg),
    .stat_o      (ir_stat)
  );

  // Merge lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_bits_q <= {ir_stat.error_d, ir_stat.detected_d, occ_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(odd_pkg::OUT_DATA_W - NC - 2)'(0), out_bits_q};

`ifndef NO_ASSERTIONS
  // A failed IR read never reports presence
  a_err_no_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[NC] && m_axis_tdata_o[NC+1]))
    else $error("ir_detected and ir_error both set");

  // An IR error leaves the debounce counter cleared
  a_err_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ir_stat.error_q |-> ir_stat.count_zero_q)
    else $error("IR counter not cleared after read failure");

  // Lane status moves only with an accepted request
  a_occ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(occ_q))
    else $error("lane status changed without a request");

  // Every accepted request leaves a result that matches the lane status
  a_out_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (m_axis_tvalid_o && (m_axis_tdata_o[NC-1:0] == occ_q)))
    else $error("result does not match lane status");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking stream testbench for the occupancy detector with debounce.
`timescale 1ns / 1ps

import odd_pkg::*;

// Tracks detector state, predicts each tick's status and checks returned results
class occupancy_tracker;
  logic [DELAY_W-1:0] on_dly[NUM_CHAN];
  logic [DELAY_W-1:0] off_dly[NUM_CHAN];
  logic [PROX_W-1:0]  prox_lim;
  logic [DELAY_W-1:0] ir_on;
  logic [DELAY_W-1:0] ir_off;
  logic [NUM_CHAN-1:0] occ;
  logic [DELAY_W-1:0] on_cnt[NUM_CHAN];
  logic [DELAY_W-1:0] off_cnt[NUM_CHAN];
  logic               ir_det;
  logic               ir_err;
  logic [DELAY_W-1:0] ir_cnt;
  logic [3:0]         status_q[$];
  int                 errors;

  function new();
    on_dly   = '{ON_DELAY_RST, ON_DELAY_RST};
    off_dly  = '{OFF_DELAY_RST, OFF_DELAY_RST};
    prox_lim = PROX_LIM_RST;
    ir_on    = IR_ON_RST;
    ir_off   = IR_OFF_RST;
    occ      = '0;
    on_cnt   = '{8'd0, 8'd0};
    off_cnt  = '{8'd0, 8'd0};
    ir_det   = 1'b0;
    ir_err   = 1'b0;
    ir_cnt   = '0;
    errors   = 0;
  endfunction

  // Mirror a register write
  function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ON_DELAY_0:   on_dly[0]  = val[DELAY_W-1:0];
      CFG_ON_DELAY_1:   on_dly[1]  = val[DELAY_W-1:0];
      CFG_OFF_DELAY_0:  off_dly[0] = val[DELAY_W-1:0];
      CFG_OFF_DELAY_1:  off_dly[1] = val[DELAY_W-1:0];
      CFG_PROX_LIMIT:   prox_lim   = val[PROX_W-1:0];
      CFG_IR_ON_COUNT:  ir_on      = val[DELAY_W-1:0];
      CFG_IR_OFF_COUNT: ir_off     = val[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance one current channel: hysteresis threshold, then on/off delay counting
  function void lane_tick(int c, logic [SAMPLE_W-1:0] cur, logic [SAMPLE_W-1:0] setpt);
    logic [SAMPLE_W:0] thr;
    logic              occ_c;
    occ_c = occ[c];
    thr   = {1'b0, setpt};
    if (occ_c && setpt >= HYST) begin
      thr = thr - HYST;
    end else if (!occ_c && setpt <= HYST_TOP) begin
      thr = thr + HYST;
    end
    if ({1'b0, cur} > thr) begin
      if (!occ_c) begin
        if (on_cnt[c] < on_dly[c]) begin
          on_cnt[c] = on_cnt[c] + 8'd1;
        end else begin
          occ[c]     = 1'b1;
          off_cnt[c] = '0;
        end
      end else begin
        off_cnt[c] = '0;
      end
    end else begin
      if (occ_c) begin
        if (off_cnt[c] < off_dly[c]) begin
          off_cnt[c] = off_cnt[c] + 8'd1;
        end else begin
          occ[c]    = 1'b0;
          on_cnt[c] = '0;
        end
      end else begin
        on_cnt[c] = '0;
      end
    end
  endfunction

  // Advance the IR debounce; the counter wraps at 8 bits
  function void ir_tick(logic [PROX_W-1:0] prox, logic ack);
    if (!ack) begin
      ir_det = 1'b0;
      ir_err = 1'b1;
      ir_cnt = '0;
    end else begin
      ir_err = 1'b0;
      if (!ir_det) begin
        if (prox >= prox_lim) begin
          ir_cnt = ir_cnt + 8'd1;
          if (ir_cnt > ir_on) begin
            ir_det = 1'b1;
            ir_cnt = '0;
          end
        end else begin
          ir_cnt = '0;
        end
      end else begin
        if (prox < prox_lim) begin
          ir_cnt = ir_cnt + 8'd1;
          if (ir_cnt > ir_off) begin
            ir_det = 1'b0;
            ir_cnt = '0;
          end
        end else begin
          ir_cnt = '0;
        end
      end
    end
  endfunction

  // Note an accepted tick and queue the status it must produce
  function void note_tick(logic [IN_DATA_W-1:0] d);
    lane_tick(0, d[9:0], d[29:20]);
    lane_tick(1, d[19:10], d[39:30]);
    ir_tick(d[55:40], d[56]);
    status_q.push_back({ir_err, ir_det, occ[1], occ[0]});
  endfunction

  // Compare a returned status with the oldest prediction
  function void check_status(logic [OUT_DATA_W-1:0] got);
    string      field_name[4];
    logic [3:0] want;
    field_name = '{"occupied_0", "occupied_1", "ir_detected", "ir_error"};
    if (status_q.size() == 0) begin
      $display("%0t: unexpected result, actual %h", $time, got);
      errors++;
      return;
    end
    want = status_q.pop_front();
    for (int f = 0; f < 4; f++) begin
      if (got[f] !== want[f]) begin
        $display("%0t: %s mismatch, expected %0d actual %0d",
                 $time, field_name[f], want[f], got[f]);
        errors++;
      end
    end
  endfunction

  function int pending();
    return status_q.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 300000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_DATA_W-1:0]   s_data = '0;
  logic                   m_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic [OUT_DATA_W-1:0]  m_data;
  logic                   cfg_ready;

  occupancy_tracker tracker = new();
  int cycle_count = 0;

  // Register values in force, used to shape the stimulus
  cfg_idx_e reg_order[7] = '{CFG_ON_DELAY_0, CFG_ON_DELAY_1, CFG_OFF_DELAY_0,
                             CFG_OFF_DELAY_1, CFG_PROX_LIMIT, CFG_IR_ON_COUNT,
                             CFG_IR_OFF_COUNT};
  int cfg_val[7] = '{4, 4, 25, 25, 768, 4, 25};

  // Run state of the stimulus generator
  bit lane_high[2];
  int lane_left[2];
  int lane_setpt[2];
  bit ir_high;
  int ir_left;
  bit send_eager = 1'b0;
  int send_calm_left = 0;
  int hold_cycles = 0;

  occupancy_detector_debounce DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_tick(int s0, int s1, int p0, int p1,
                                                     int prox, int ack);
    return {7'd0, 1'(ack), 16'(prox), 10'(p1), 10'(p0), 10'(s1), 10'(s0)};
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Draw the next tick: held levels per channel with random content and some noise
  function automatic logic [IN_DATA_W-1:0] next_tick();
    int cur[2];
    int dly;
    int r;
    int prox;
    int ack;
    int lim;
    for (int c = 0; c < 2; c++) begin
      if (lane_left[c] == 0) begin
        lane_high[c] = $urandom_range(0, 1);
        dly = (cfg_val[c] > cfg_val[c+2]) ? cfg_val[c] : cfg_val[c+2];
        lane_left[c] = $urandom_range(0, 1) ? dly + 1 + $urandom_range(0, 3)
                                            : $urandom_range(1, 8);
        r = $urandom_range(0, 7);
        lane_setpt[c] = (r == 0) ? $urandom_range(0, 6) :
                        (r == 1) ? $urandom_range(1016, 1023) : $urandom_range(0, 1023);
      end
      lane_left[c]--;
      r = $urandom_range(0, 15);
      if (r == 0) begin
        cur[c] = $urandom_range(0, 1023);
      end else if (r == 1) begin
        cur[c] = clip(lane_setpt[c] + $urandom_range(0, 12) - 6, 0, 1023);
      end else if (lane_high[c]) begin
        cur[c] = clip(lane_setpt[c] + 6 + $urandom_range(0, 40), 0, 1023);
      end else begin
        cur[c] = clip(lane_setpt[c] - 6 - $urandom_range(0, 40), 0, 1023);
      end
    end
    if (ir_left == 0) begin
      ir_high = $urandom_range(0, 1);
      dly = (cfg_val[5] > cfg_val[6]) ? cfg_val[5] : cfg_val[6];
      ir_left = $urandom_range(0, 1) ? dly + 2 + $urandom_range(0, 3) : $urandom_range(1, 8);
    end
    ir_left--;
    lim = cfg_val[4];
    if ($urandom_range(0, 15) == 0) begin
      prox = $urandom_range(0, 65535);
    end else if (ir_high || lim == 0) begin
      prox = $urandom_range(65535, lim);
    end else begin
      prox = $urandom_range(lim - 1, 0);
    end
    ack = ($urandom_range(0, 19) != 0);
    return pack_tick(cur[0], cur[1], lane_setpt[0], lane_setpt[1], prox, ack);
  endfunction

  // Offer one tick after a random gap and note it once accepted
  task automatic send_tick(logic [IN_DATA_W-1:0] d);
    int gap;
    if (send_eager || send_calm_left > 0) begin
      gap = 0;
      if (send_calm_left > 0) send_calm_left--;
    end else if ($urandom_range(0, 24) == 0) begin
      send_calm_left = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    do @(negedge clk_i); while (!s_ready);
    @(posedge clk_i);
    tracker.note_tick(d);
  endtask

  task automatic random_phase(int count, int eager_count);
    lane_left = '{0, 0};
    ir_left   = 0;
    for (int n = 0; n < count; n++) begin
      send_eager = (n < eager_count);
      send_tick(next_tick());
    end
    send_eager = 1'b0;
    s_valid <= 1'b0;
  endtask

  // Hold until every predicted status has come back
  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all registers from cfg_val, keeping valid high across the burst
  task automatic write_regs();
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= CFG_DATA_W'(cfg_val[i]);
      do @(negedge clk_i); while (!cfg_ready);
      @(posedge clk_i);
      tracker.set_reg(reg_order[i], CFG_DATA_W'(cfg_val[i]));
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, calm stretches and one long hold-off on request
  initial begin
    int gap;
    int calm_left;
    logic [OUT_DATA_W-1:0] got;
    calm_left = 0;
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        m_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      if (calm_left > 0) begin
        calm_left--;
        gap = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        calm_left = $urandom_range(10, 40);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(negedge clk_i); while (!m_valid);
      got = m_data;
      @(posedge clk_i);
      tracker.check_status(got);
    end
  end

  // Main sequence: reset, directed ticks, then register settings with random ticks
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, hysteresis edges, IR limit boundary and a missing ack under reset values
    send_tick(pack_tick(0, 0, 0, 0, 0, 1));
    send_tick(pack_tick(1023, 1023, 1023, 1023, 65535, 1));
    repeat (6) send_tick(pack_tick(1023, 1023, 1019, 1018, 768, 1));
    send_tick(pack_tick(4, 0, 4, 0, 767, 1));
    send_tick(pack_tick(5, 1023, 4, 500, 767, 1));
    send_tick(pack_tick(1023, 1023, 1023, 500, 0, 0));
    send_tick(pack_tick(1018, 1023, 1023, 500, 65535, 1));
    send_tick(pack_tick(0, 1023, 5, 500, 1000, 1));
    send_tick(pack_tick(10, 0, 5, 1023, 768, 1));
    send_tick(pack_tick('h2AA, 'h155, 'h155, 'h2AA, 'hAAAA, 1));
    send_tick(pack_tick('h155, 'h2AA, 'h2AA, 'h155, 'h5555, 0));
    send_tick(pack_tick(1023, 0, 1023, 0, 767, 1));
    s_valid <= 1'b0;
    drain();
    random_phase(100, 0);
    drain();

    // Zero delays and limits: status follows on the first qualifying tick
    cfg_val = '{0, 0, 0, 0, 0, 0, 0};
    write_regs();
    hold_cycles = 150;
    random_phase(90, 60);
    drain();

    // Longest delays; the IR count wraps so the debounce never flips detection, only a failed read clears it
    cfg_val = '{255, 255, 255, 255, 65535, 255, 255};
    write_regs();
    random_phase(300, 0);
    drain();

    // Mixed edges of the listed ranges
    cfg_val = '{1, 254, 254, 1, 768, 254, 0};
    write_regs();
    random_phase(100, 0);
    drain();

    // Random short settings
    for (int p = 0; p < 2; p++) begin
      cfg_val = '{$urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                  $urandom_range(1, 12), $urandom_range(0, 65535), $urandom_range(0, 12),
                  $urandom_range(0, 12)};
      write_regs();
      random_phase(80, 0);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
